// ----- hw/rtl/crsu_pkg.sv -----
// Shared types and constants for the Catmull-Rom segment upsampler.
`default_nettype none

package crsu_pkg;

	// Fixed field widths of the sample and point beats
	localparam int SAMPLE_BITS = 10;
	localparam int OUT_BITS    = SAMPLE_BITS + 2;
	localparam int COL_BITS    = 4;

	// Datapath sizing that follows from the sample width
	localparam int COEF_BITS   = SAMPLE_BITS + 5;  // holds A, B, C of a segment
	localparam int QBIAS_LOG   = SAMPLE_BITS + 3;  // quotient bias keeps the dividend >= 0
	localparam int NN_EXTRA    = SAMPLE_BITS + 6;  // dividend bits above log2(W^3)
	localparam int QUO_BITS    = SAMPLE_BITS + 6;  // biased quotient bits
	localparam int VAL_BITS    = QUO_BITS + 2;     // signed height before saturation

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   curve_end;
	} sample_beat_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] point_height;
		logic [COL_BITS-1:0]        column;
		logic                       run_last;
		logic                       curve_done;
	} point_beat_t;

	// Operand sources for a segment's four control points
	typedef enum logic [1:0] {
		SRC_H0   = 2'd0,
		SRC_H1   = 2'd1,
		SRC_H2   = 2'd2,
		SRC_SAMP = 2'd3
	} op_src_t;

	// Segment kinds a sample can cause
	typedef enum logic [1:0] {
		SEG_BODY  = 2'd0,
		SEG_TAIL  = 2'd1,
		SEG_FINAL = 2'd2
	} seg_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_PLAN = 3'd1,
		ST_LOAD = 3'd2,
		ST_INIT = 3'd3,
		ST_RUN  = 3'd4
	} ctrl_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic                capture;
		logic                load_coef;
		logic                init_gen;
		logic                issue;
		op_src_t             src_yp;
		op_src_t             src_y0;
		op_src_t             src_y1;
		op_src_t             src_y2;
		logic                final_seg;
		logic [COL_BITS-1:0] column;
		logic                run_last;
		logic                curve_done;
		logic                commit_shift;
		logic                commit_clear;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/crsu_ctrl.sv -----
// Controller: sample intake, segment sequencing and history commit.
`default_nettype none

module crsu_ctrl #(
	parameter int SEGMENT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	input  logic                curve_end,
	output logic                sample_stall,
	input  logic                advance,
	output crsu_pkg::ctrl_cmd_t cmd
);
	import crsu_pkg::*;

	localparam int CNT_BITS = (SEGMENT_WIDTH > 1) ? $clog2(SEGMENT_WIDTH) : 1;
	localparam logic [CNT_BITS-1:0] LAST_COL = CNT_BITS'(SEGMENT_WIDTH - 1);

	ctrl_state_t         state_q, state_d;
	seg_kind_t           seg_q, seg_d;
	logic [1:0]          seen_q, seen_d;
	logic                end_q, end_d;
	logic [CNT_BITS-1:0] col_q, col_d;
	logic [CNT_BITS+COL_BITS-1:0] col_ext;
	logic                at_last;
	logic [1:0]          seen_inc;

	assign col_ext  = {{COL_BITS{1'b0}}, col_q};
	assign at_last  = (col_q == LAST_COL);
	assign seen_inc = (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= SEG_BODY;
			seen_q  <= 2'd0;
			end_q   <= 1'b0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			seen_q  <= seen_d;
			end_q   <= end_d;
			col_q   <= col_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		seg_d        = seg_q;
		seen_d       = seen_q;
		end_d        = end_q;
		col_d        = col_q;
		sample_stall = 1'b1;
		cmd          = '0;

		// operand selection for the segment being loaded
		unique case (seg_q)
			SEG_BODY: begin
				cmd.src_yp = (seen_q == 2'd3) ? SRC_H0 : SRC_H1;
				cmd.src_y0 = SRC_H1;
				cmd.src_y1 = SRC_H2;
				cmd.src_y2 = SRC_SAMP;
			end
			SEG_TAIL: begin
				cmd.src_yp = (seen_q >= 2'd2) ? SRC_H1 : SRC_H2;
				cmd.src_y0 = SRC_H2;
				cmd.src_y1 = SRC_SAMP;
				cmd.src_y2 = SRC_SAMP;
			end
			SEG_FINAL: begin
				cmd.src_yp    = (seen_q >= 2'd1) ? SRC_H2 : SRC_SAMP;
				cmd.src_y0    = SRC_SAMP;
				cmd.src_y1    = SRC_SAMP;
				cmd.src_y2    = SRC_SAMP;
				cmd.final_seg = 1'b1;
			end
			default: begin
				cmd.src_yp = SRC_SAMP;
				cmd.src_y0 = SRC_SAMP;
				cmd.src_y1 = SRC_SAMP;
				cmd.src_y2 = SRC_SAMP;
			end
		endcase

		// point tags
		cmd.column     = col_ext[COL_BITS-1:0];
		cmd.run_last   = at_last && ((seg_q == SEG_FINAL) || ((seg_q == SEG_BODY) && !end_q));
		cmd.curve_done = at_last && (seg_q == SEG_FINAL);

		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.capture = 1'b1;
					end_d       = curve_end;
					state_d     = ST_PLAN;
				end
			end
			ST_PLAN: begin
				if (seen_q >= 2'd2) begin
					seg_d   = SEG_BODY;
					state_d = ST_LOAD;
				end else if (end_q) begin
					seg_d   = (seen_q >= 2'd1) ? SEG_TAIL : SEG_FINAL;
					state_d = ST_LOAD;
				end else begin
					cmd.commit_shift = 1'b1;
					seen_d           = seen_inc;
					state_d          = ST_IDLE;
				end
			end
			ST_LOAD: begin
				cmd.load_coef = 1'b1;
				state_d       = ST_INIT;
			end
			ST_INIT: begin
				cmd.init_gen = 1'b1;
				col_d        = '0;
				state_d      = ST_RUN;
			end
			ST_RUN: begin
				if (advance) begin
					cmd.issue = 1'b1;
					col_d     = col_q + CNT_BITS'(1);
					if (at_last) begin
						unique case (seg_q)
							SEG_BODY: begin
								if (end_q) begin
									seg_d   = SEG_TAIL;
									state_d = ST_LOAD;
								end else begin
									cmd.commit_shift = 1'b1;
									seen_d           = seen_inc;
									state_d          = ST_IDLE;
								end
							end
							SEG_TAIL: begin
								seg_d   = SEG_FINAL;
								state_d = ST_LOAD;
							end
							default: begin
								cmd.commit_clear = 1'b1;
								seen_d           = 2'd0;
								end_d            = 1'b0;
								state_d          = ST_IDLE;
							end
						endcase
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/crsu_datapath.sv -----
// Datapath: history, segment coefficients, cubic generator and rounding pipeline.
`default_nettype none

module crsu_datapath #(
	parameter int SEGMENT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  crsu_pkg::sample_beat_t sample_data,
	input  crsu_pkg::ctrl_cmd_t    cmd,
	output logic                   advance,
	output logic                   point_valid,
	input  logic                   point_stall,
	output crsu_pkg::point_beat_t  point_data
);
	import crsu_pkg::*;

	localparam int W2       = SEGMENT_WIDTH * SEGMENT_WIDTH;
	localparam int W3       = W2 * SEGMENT_WIDTH;
	localparam int DIVISOR  = 2 * W3;
	localparam int NN_BITS  = $clog2(W3) + NN_EXTRA;
	localparam int ACC_BITS = NN_BITS + 1;
	localparam longint OFFSET = longint'(W3) + (longint'(DIVISOR) << QBIAS_LOG);
	localparam longint RECIP  = (longint'(1) << NN_BITS) / longint'(DIVISOR);
	localparam int SAT_LO_I = -(1 << (SAMPLE_BITS - 1));
	localparam int SAT_HI_I = (3 << (SAMPLE_BITS - 1)) - 1;

	localparam logic signed [ACC_BITS-1:0] W_ACC    = ACC_BITS'(SEGMENT_WIDTH);
	localparam logic signed [ACC_BITS-1:0] W2_ACC   = ACC_BITS'(W2);
	localparam logic        [NN_BITS-1:0]  OFFSET_V = NN_BITS'(OFFSET);
	localparam logic        [NN_BITS-1:0]  RECIP_V  = NN_BITS'(RECIP);
	localparam logic        [NN_BITS-1:0]  DIV_V    = NN_BITS'(DIVISOR);
	localparam logic signed [VAL_BITS-1:0] QBIAS_V  = VAL_BITS'(1 << QBIAS_LOG);
	localparam logic signed [VAL_BITS-1:0] SAT_LO   = VAL_BITS'(SAT_LO_I);
	localparam logic signed [VAL_BITS-1:0] SAT_HI   = VAL_BITS'(SAT_HI_I);

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic signed [ACC_BITS-1:0]  acc_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] y0;
		logic [COL_BITS-1:0]    column;
		logic                   run_last;
		logic                   curve_done;
	} pt_tag_t;

	// history and the sample being worked on
	logic [SAMPLE_BITS-1:0] hist_q [3];
	logic [SAMPLE_BITS-1:0] samp_q;

	// operand mux
	function automatic coef_t pick(input op_src_t src,
	                               input logic [SAMPLE_BITS-1:0] h0,
	                               input logic [SAMPLE_BITS-1:0] h1,
	                               input logic [SAMPLE_BITS-1:0] h2,
	                               input logic [SAMPLE_BITS-1:0] s);
		logic [SAMPLE_BITS-1:0] v;
		case (src)
			SRC_H0:  v = h0;
			SRC_H1:  v = h1;
			SRC_H2:  v = h2;
			default: v = s;
		endcase
		return $signed(COEF_BITS'(v));
	endfunction

	coef_t yp_e, y0_e, y1_e, y2_e;
	coef_t dd, m0, m1, ca, cb;
	coef_t coef_a_q, coef_b_q, coef_c_q;
	logic [SAMPLE_BITS-1:0] base_q;

	assign yp_e = pick(cmd.src_yp, hist_q[0], hist_q[1], hist_q[2], samp_q);
	assign y0_e = pick(cmd.src_y0, hist_q[0], hist_q[1], hist_q[2], samp_q);
	assign y1_e = pick(cmd.src_y1, hist_q[0], hist_q[1], hist_q[2], samp_q);
	assign y2_e = pick(cmd.src_y2, hist_q[0], hist_q[1], hist_q[2], samp_q);

	// Hermite coefficients with central-difference tangents
	assign dd = y1_e - y0_e;
	assign m0 = y1_e - yp_e;
	assign m1 = cmd.final_seg ? m0 : (y2_e - y0_e);
	assign ca = m0 + m1 - (dd <<< 2);
	assign cb = (dd <<< 2) + (dd <<< 1) - (m0 <<< 1) - m1;

	// forward-difference generator of N(j) = A j^3 + B W j^2 + C W^2 j
	acc_t a_x, bw, cw2;
	acc_t acc_q, d1_q, d2_q, d3_q;
	acc_t nn_sum;

	assign a_x    = ACC_BITS'(coef_a_q);
	assign bw     = ACC_BITS'(coef_b_q) * W_ACC;
	assign cw2    = ACC_BITS'(coef_c_q) * W2_ACC;
	assign nn_sum = acc_q + $signed({1'b0, OFFSET_V});

	// history, operands and generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= '0;
			hist_q[1] <= '0;
			hist_q[2] <= '0;
		end else if (cmd.commit_clear) begin
			hist_q[0] <= '0;
			hist_q[1] <= '0;
			hist_q[2] <= '0;
		end else if (cmd.commit_shift) begin
			hist_q[0] <= hist_q[1];
			hist_q[1] <= hist_q[2];
			hist_q[2] <= samp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			samp_q <= sample_data.sample;
		end
		if (cmd.load_coef) begin
			coef_a_q <= ca;
			coef_b_q <= cb;
			coef_c_q <= m0;
			base_q   <= y0_e[SAMPLE_BITS-1:0];
		end
		if (cmd.init_gen) begin
			acc_q <= '0;
			d1_q  <= a_x + bw + cw2;
			d2_q  <= (a_x <<< 2) + (a_x <<< 1) + (bw <<< 1);
			d3_q  <= (a_x <<< 2) + (a_x <<< 1);
		end else if (cmd.issue) begin
			acc_q <= acc_q + d1_q;
			d1_q  <= d1_q + d2_q;
			d2_q  <= d2_q + d3_q;
		end
	end

	// rounding pipeline: reciprocal estimate, back-multiply, correction, output
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	pt_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [NN_BITS-1:0]   nn_s1, nn_s2, nn_s3;
	logic [2*NN_BITS-1:0] prod;
	logic [QUO_BITS-1:0]  qe_s2, qe_s3, qc_s4;
	logic [NN_BITS-1:0]   qd, qd_s3, rem;
	logic signed [VAL_BITS-1:0] val, sat;
	point_beat_t out_q;

	assign advance = !out_valid_q || !point_stall;
	assign prod    = {{NN_BITS{1'b0}}, nn_s1} * {{NN_BITS{1'b0}}, RECIP_V};
	assign qd      = NN_BITS'(qe_s2) * DIV_V;
	assign rem     = nn_s3 - qd_s3;

	// height = base + corrected quotient - bias, then clamp
	assign val = $signed({2'b00, qc_s4}) + $signed(VAL_BITS'(tag_s4.y0)) - QBIAS_V;
	always_comb begin
		if (val < SAT_LO) begin
			sat = SAT_LO;
		end else if (val > SAT_HI) begin
			sat = SAT_HI;
		end else begin
			sat = val;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (advance) begin
			nn_s1             <= nn_sum[NN_BITS-1:0];
			tag_s1.y0         <= base_q;
			tag_s1.column     <= cmd.column;
			tag_s1.run_last   <= cmd.run_last;
			tag_s1.curve_done <= cmd.curve_done;

			nn_s2  <= nn_s1;
			qe_s2  <= prod[NN_BITS +: QUO_BITS];
			tag_s2 <= tag_s1;

			nn_s3  <= nn_s2;
			qe_s3  <= qe_s2;
			qd_s3  <= qd;
			tag_s3 <= tag_s2;

			qc_s4  <= qe_s3 + QUO_BITS'(rem >= DIV_V);
			tag_s4 <= tag_s3;

			out_q.point_height <= sat[OUT_BITS-1:0];
			out_q.column       <= tag_s4.column;
			out_q.run_last     <= tag_s4.run_last;
			out_q.curve_done   <= tag_s4.curve_done;
		end
	end

	assign point_valid = out_valid_q;
	assign point_data  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/catmull_rom_segment_upsampler.sv -----
// Top level of the Catmull-Rom segment upsampler.
//
// Each accepted sample beat causes zero to three segments of SEGMENT_WIDTH
// points: a sample in the middle of a curve releases the segment two samples
// back, and a sample flagged curve_end also flushes the last two segments. A
// sample is taken only while the controller is idle; it then plans, and each
// segment forms its coefficients, seeds the forward-difference generator and
// issues its SEGMENT_WIDTH points, one point a cycle while the output does not
// stall. Points pass through the registered rounding pipeline to the output
// register; output stall freezes the pipeline and the generator together. No
// points come from the first two samples of a curve unless one of them ends it.

`default_nettype none

module catmull_rom_segment_upsampler #(
	parameter int SEGMENT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  crsu_pkg::sample_beat_t sample_data,
	output logic                   point_valid,
	input  logic                   point_stall,
	output crsu_pkg::point_beat_t  point_data
);
	import crsu_pkg::*;

	localparam logic [COL_BITS-1:0] LAST_COL = COL_BITS'(SEGMENT_WIDTH - 1);

	ctrl_cmd_t cmd;
	logic      advance;

	crsu_ctrl #(
		.SEGMENT_WIDTH(SEGMENT_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.curve_end   (sample_data.curve_end),
		.sample_stall(sample_stall),
		.advance     (advance),
		.cmd         (cmd)
	);

	crsu_datapath #(
		.SEGMENT_WIDTH(SEGMENT_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_data(sample_data),
		.cmd        (cmd),
		.advance    (advance),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point_data (point_data)
	);

	// end of curve always closes the beat run of its sample
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_data.curve_done |-> point_data.run_last)
		else $error("curve_done without run_last");

	// the last point of a run sits in the last column of its segment
	a_last_column: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_data.run_last |-> point_data.column == LAST_COL)
		else $error("run_last away from the last column");

	// the generator only issues while the pipeline moves
	a_issue_flows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> advance)
		else $error("point issued into a stalled pipeline");

	// no sample beat is taken while segments are still being issued
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> sample_stall)
		else $error("sample accepted during a segment");

endmodule

`default_nettype wire
